// ===== src/ldte_pkg.sv =====
// package for the local date to epoch milliseconds block
// status codes, shared record types and the calendar tables
// no dependencies
`default_nettype none

package ldte_pkg;

    localparam int ERA_DAYS    = 146097;
    localparam int CIVIL_SHIFT = 719468;
    localparam int BASE_YEAR   = 2000;
    // era before the base year, so january and february of 2000 stay positive
    localparam int BASE_ERA    = BASE_YEAR / 400 - 1;
    localparam int YOE_BASE    = BASE_YEAR - BASE_ERA * 400;
    localparam int DAY_BIAS    = CIVIL_SHIFT - BASE_ERA * ERA_DAYS;
    localparam int MAX_YEAR_OFS = 2099 - BASE_YEAR;
    localparam int FRAME_LEN   = 7;
    localparam int MS_PER_SEC  = 1000;
    localparam int SEC_PER_DAY = 86400;

    localparam int ZONE_W   = 17;
    localparam int EPOCH_W  = 42;
    localparam int DAYS_W   = 16;
    localparam int TOD_W    = 17;

    localparam logic signed [ZONE_W-1:0] ZONE_RESET = ZONE_W'(-10800);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FRAME = 2'd1,
        ST_DATE  = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [DAYS_W-1:0]  days;
        logic [TOD_W-1:0]   tod;
    } t_date_info;

    // days in month, index 0 is january, february without leap day
    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // (153 * mp + 2) / 5, march based month index
    function automatic logic [8:0] doy_base(input logic [3:0] mp);
        logic [8:0] base;
        case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== src/ldte_check.sv =====
// framing and date check plus day count since 1970 and time of day
// combinational, uses ldte_pkg
`default_nettype none

module ldte_check (
    input  wire logic [8:0]          i_write_offset,
    input  wire logic [7:0]          i_payload_length,
    input  wire logic [7:0]          i_year_since_2000,
    input  wire logic [7:0]          i_month_number,
    input  wire logic [7:0]          i_day_of_month,
    input  wire logic [7:0]          i_hour_of_day,
    input  wire logic [7:0]          i_minute_of_hour,
    input  wire logic [7:0]          i_second_of_minute,
    output ldte_pkg::t_date_info     o_info
);
    import ldte_pkg::*;

    logic        frame_bad;
    logic        mon_ok;
    logic        early;
    logic        leap;
    logic [3:0]  mon_idx;
    logic [3:0]  mp;
    logic [4:0]  dim;
    logic        date_bad;
    logic [8:0]  yoe;
    logic [2:0]  centuries;
    logic        quads;
    logic [8:0]  doy;
    logic [19:0] days_full;

    always_comb begin
        frame_bad = (i_write_offset != 9'd0) || (i_payload_length != 8'(FRAME_LEN));
        mon_ok    = (i_month_number >= 8'd1) && (i_month_number <= 8'd12);
        early     = (i_month_number <= 8'd2);
        // 2000 is a leap year, 2100 is outside range
        leap      = (i_year_since_2000[1:0] == 2'b00);
        mon_idx   = i_month_number[3:0] - 4'd1;
        dim       = month_len(mon_idx)
                  + 5'((i_month_number == 8'd2) && leap);
        date_bad  = (i_year_since_2000 > 8'(MAX_YEAR_OFS)) || !mon_ok
                  || (i_hour_of_day > 8'd23) || (i_minute_of_hour > 8'd59)
                  || (i_second_of_minute > 8'd59)
                  || (i_day_of_month == 8'd0)
                  || (i_day_of_month > {3'b000, dim});

        mp        = early ? (i_month_number[3:0] + 4'd9) : (i_month_number[3:0] - 4'd3);
        yoe       = 9'(YOE_BASE) + {1'b0, i_year_since_2000} - 9'(early);
        // yoe / 100 and yoe / 400 for yoe in 399..499
        centuries = (yoe >= 9'd400) ? 3'd4 : 3'd3;
        quads     = (yoe >= 9'd400);
        doy       = doy_base(mp) + {1'b0, i_day_of_month} - 9'd1;
        days_full = 20'(yoe) * 20'd365 + 20'(yoe[8:2]) - 20'(centuries) + 20'(quads)
                  + 20'(doy) - 20'(DAY_BIAS);

        if (frame_bad) begin
            o_info.status = ST_FRAME;
        end else if (date_bad) begin
            o_info.status = ST_DATE;
        end else begin
            o_info.status = ST_OK;
        end
        o_info.days = days_full[DAYS_W-1:0];
        o_info.tod  = TOD_W'(i_hour_of_day[4:0]) * TOD_W'(3600)
                    + TOD_W'(i_minute_of_hour[5:0]) * TOD_W'(60)
                    + TOD_W'(i_second_of_minute[5:0]);
    end

endmodule

`default_nettype wire

// ===== src/local_date_to_epoch_ms_top.sv =====
// top level: time-sync record to utc epoch milliseconds
// uses ldte_pkg and ldte_check
//
// usage:
//   input channel: drive the record fields and pulse start; a beat is taken
//   at each rising edge with start high and busy low. busy is always low,
//   so a new beat may be offered in every cycle.
//   result channel: o_valid is high for exactly one cycle with o_status and
//   o_epoch_ms; the receiver cannot stall, so results are never held.
//   every beat gives exactly one result, in order.
//   path: each beat passes the input register, the check and day count stage
//   and the multiply and sum stage before o_valid rises with its result.
//   throughput: one beat per cycle; busy never rises and every stage moves
//   each cycle.
//   config: i_cfg_we writes the signed zone offset in seconds; write it only
//   while no beat is in flight.
//   reset: synchronous active low; clears the pipeline valids and loads the
//   zone offset with -10800 s.
`default_nettype none

module local_date_to_epoch_ms_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic [8:0]                   i_write_offset,
    input  wire logic [7:0]                   i_payload_length,
    input  wire logic [7:0]                   i_year_since_2000,
    input  wire logic [7:0]                   i_month_number,
    input  wire logic [7:0]                   i_day_of_month,
    input  wire logic [7:0]                   i_hour_of_day,
    input  wire logic [7:0]                   i_minute_of_hour,
    input  wire logic [7:0]                   i_second_of_minute,
    input  wire logic                         i_cfg_we,
    input  wire logic [ldte_pkg::ZONE_W-1:0]  i_cfg_wdata,
    output      logic                         o_valid,
    output      logic [1:0]                   o_status,
    output      logic [ldte_pkg::EPOCH_W-1:0] o_epoch_ms
);
    import ldte_pkg::*;

    localparam int        SUM_W      = 44;
    localparam logic [SUM_W-1:0] MS_PER_DAY = SUM_W'(SEC_PER_DAY * MS_PER_SEC);
    localparam logic [SUM_W-1:0] MS_SCALE   = SUM_W'(MS_PER_SEC);

    logic signed [ZONE_W-1:0]  r_zone;
    logic                      r_in_vld;
    logic [8:0]                r_woff;
    logic [7:0]                r_plen;
    logic [7:0]                r_year;
    logic [7:0]                r_mon;
    logic [7:0]                r_day;
    logic [7:0]                r_hr;
    logic [7:0]                r_min;
    logic [7:0]                r_sec;
    logic                      r_mid_vld;
    t_date_info                r_mid;
    t_date_info                n_mid;
    logic                      r_out_vld;
    t_status                   r_out_status;
    logic [EPOCH_W-1:0]        r_out_epoch;
    logic [EPOCH_W-1:0]        n_out_epoch;
    logic [SUM_W-1:0]          day_ms;
    logic [SUM_W-1:0]          tod_ms;
    logic [SUM_W-1:0]          zone_ms;
    logic [SUM_W-1:0]          sum_ms;
    logic                      accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_woff <= i_write_offset;
            r_plen <= i_payload_length;
            r_year <= i_year_since_2000;
            r_mon  <= i_month_number;
            r_day  <= i_day_of_month;
            r_hr   <= i_hour_of_day;
            r_min  <= i_minute_of_hour;
            r_sec  <= i_second_of_minute;
        end
    end

    ldte_check u_check (
        .i_write_offset     (r_woff),
        .i_payload_length   (r_plen),
        .i_year_since_2000  (r_year),
        .i_month_number     (r_mon),
        .i_day_of_month     (r_day),
        .i_hour_of_day      (r_hr),
        .i_minute_of_hour   (r_min),
        .i_second_of_minute (r_sec),
        .o_info             (n_mid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
        end else begin
            r_mid_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_mid <= n_mid;
        end
    end

    // constant multiplies and the utc sum
    always_comb begin
        day_ms  = SUM_W'(r_mid.days) * MS_PER_DAY;
        tod_ms  = SUM_W'(r_mid.tod) * MS_SCALE;
        zone_ms = SUM_W'(r_zone) * MS_SCALE;
        sum_ms  = day_ms + tod_ms - zone_ms;
        n_out_epoch = (r_mid.status == ST_OK) ? sum_ms[EPOCH_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_mid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mid_vld) begin
            r_out_status <= r_mid.status;
            r_out_epoch  <= n_out_epoch;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_status   = r_out_status;
    assign o_epoch_ms = r_out_epoch;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_valid)
        else $error("result missing three cycles after accepted beat");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_epoch_ms == '0))
        else $error("nonzero epoch on error status");

    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK)) |-> (o_epoch_ms != '0))
        else $error("zero epoch on valid date");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench for local_date_to_epoch_ms_top: time-sync records in, utc epoch ms out
// checks each result against a typed table row or a local predictor under several zone offsets
// depends on ldte_pkg and the block's rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ldte_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PIPE_CYCLES = 6;
    localparam int PHASE_BEATS = 150;
    localparam int DIR_ROWS    = 25;

    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [8:0] write_offset;
        logic [7:0] payload_length;
        logic [7:0] year_ofs;
        logic [7:0] month;
        logic [7:0] mday;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] sec;
    } t_sync_rec;

    typedef struct packed {
        t_status              status;
        logic [EPOCH_W-1:0]   utc_ms;
    } t_utc_result;

    typedef struct packed {
        t_sync_rec   rec;
        logic        typed;
        t_utc_result res;
    } t_dir_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [8:0]                 i_write_offset = '0;
    logic [7:0]                 i_payload_length = '0;
    logic [7:0]                 i_year_since_2000 = '0;
    logic [7:0]                 i_month_number = '0;
    logic [7:0]                 i_day_of_month = '0;
    logic [7:0]                 i_hour_of_day = '0;
    logic [7:0]                 i_minute_of_hour = '0;
    logic [7:0]                 i_second_of_minute = '0;
    logic                       i_cfg_we = 1'b0;
    logic [ZONE_W-1:0]          i_cfg_wdata = '0;
    logic                       o_valid;
    logic [1:0]                 o_status;
    logic [EPOCH_W-1:0]         o_epoch_ms;

    logic signed [ZONE_W-1:0]   zone_cfg = ZONE_RESET;
    t_utc_result                utc_expect_q [$];
    int                         err_cnt = 0;
    int                         n_converted = 0;
    int                         n_framing = 0;
    int                         n_bad_date = 0;
    int                         zone_writes = 0;
    int                         idle_cycles = 0;
    bit                         no_idle = 1'b0;

    t_dir_row dir_tbl [DIR_ROWS] = '{
        '{'{9'd0,   8'd7,   8'd0,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_OK, 42'd946695600000}},
        '{'{9'd0,   8'd7,   8'd99,  8'd12,  8'd31,  8'd23,  8'd59,  8'd59},  1'b1,
          '{ST_OK, 42'd4102455599000}},
        '{'{9'd1,   8'd7,   8'd24,  8'd6,   8'd15,  8'd12,  8'd0,   8'd0},   1'b1,
          '{ST_FRAME, 42'd0}},
        '{'{9'd511, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{ST_FRAME, 42'd0}},
        '{'{9'd0,   8'd6,   8'd24,  8'd6,   8'd15,  8'd12,  8'd0,   8'd0},   1'b1,
          '{ST_FRAME, 42'd0}},
        '{'{9'd0,   8'd8,   8'd24,  8'd6,   8'd15,  8'd12,  8'd0,   8'd0},   1'b1,
          '{ST_FRAME, 42'd0}},
        '{'{9'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_FRAME, 42'd0}},
        '{'{9'd3,   8'd7,   8'd200, 8'd0,   8'd0,   8'd99,  8'd99,  8'd99},  1'b1,
          '{ST_FRAME, 42'd0}},
        '{'{9'd0,   8'd7,   8'd100, 8'd1,   8'd1,   8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd255, 8'd1,   8'd1,   8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd10,  8'd0,   8'd1,   8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd10,  8'd13,  8'd1,   8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd10,  8'd255, 8'd255, 8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd10,  8'd5,   8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd10,  8'd1,   8'd32,  8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd10,  8'd4,   8'd31,  8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd10,  8'd5,   8'd5,   8'd24,  8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd10,  8'd5,   8'd5,   8'd0,   8'd60,  8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd10,  8'd5,   8'd5,   8'd0,   8'd0,   8'd60},  1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd23,  8'd2,   8'd29,  8'd0,   8'd0,   8'd0},   1'b1,
          '{ST_DATE, 42'd0}},
        '{'{9'd0,   8'd7,   8'd24,  8'd2,   8'd29,  8'd12,  8'd30,  8'd30},  1'b0,
          '{ST_OK, 42'd0}},
        '{'{9'd0,   8'd7,   8'd0,   8'd2,   8'd29,  8'd23,  8'd59,  8'd59},  1'b0,
          '{ST_OK, 42'd0}},
        '{'{9'd0,   8'd7,   8'd1,   8'd2,   8'd28,  8'd23,  8'd59,  8'd59},  1'b0,
          '{ST_OK, 42'd0}},
        '{'{9'd0,   8'd7,   8'd0,   8'd3,   8'd1,   8'd0,   8'd0,   8'd0},   1'b0,
          '{ST_OK, 42'd0}},
        '{'{9'd0,   8'd7,   8'd57,  8'd11,  8'd30,  8'd7,   8'd45,  8'd13},  1'b0,
          '{ST_OK, 42'd0}}
    };

    local_date_to_epoch_ms_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_write_offset     (i_write_offset),
        .i_payload_length   (i_payload_length),
        .i_year_since_2000  (i_year_since_2000),
        .i_month_number     (i_month_number),
        .i_day_of_month     (i_day_of_month),
        .i_hour_of_day      (i_hour_of_day),
        .i_minute_of_hour   (i_minute_of_hour),
        .i_second_of_minute (i_second_of_minute),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_epoch_ms         (o_epoch_ms)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned month_days(int unsigned year, int unsigned mon);
        int unsigned dim;
        dim = MONTH_LEN[mon - 1];
        if (mon == 2 && (((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0)))
            dim = 29;
        return dim;
    endfunction

    function automatic t_utc_result convert_record(t_sync_rec r, logic signed [ZONE_W-1:0] zone);
        t_utc_result res;
        int unsigned year, yy, era, yoe, mp, doy, doe;
        longint      days, secs;
        res.status   = ST_OK;
        res.utc_ms   = '0;
        if (r.write_offset != 0 || r.payload_length != FRAME_LEN) begin
            res.status = ST_FRAME;
            return res;
        end
        year = BASE_YEAR + r.year_ofs;
        if (r.year_ofs > MAX_YEAR_OFS || r.month < 1 || r.month > 12 || r.hour > 23
                || r.minute > 59 || r.sec > 59) begin
            res.status = ST_DATE;
            return res;
        end
        if (r.mday < 1 || r.mday > month_days(year, r.month)) begin
            res.status = ST_DATE;
            return res;
        end
        // march-based year so the leap day falls at the end
        yy   = year - ((r.month <= 2) ? 1 : 0);
        era  = yy / 400;
        yoe  = yy - era * 400;
        mp   = (r.month > 2) ? r.month - 3 : r.month + 9;
        doy  = (153 * mp + 2) / 5 + r.mday - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = longint'(era) * ERA_DAYS + longint'(doe) - CIVIL_SHIFT;
        secs = days * SEC_PER_DAY + longint'(r.hour) * 3600 + longint'(r.minute) * 60
             + longint'(r.sec) - longint'(zone);
        res.utc_ms = EPOCH_W'(secs * MS_PER_SEC);
        return res;
    endfunction

    function automatic t_sync_rec rand_record();
        t_sync_rec r;
        int unsigned dim, pick;
        r.write_offset   = '0;
        r.payload_length = 8'(FRAME_LEN);
        r.year_ofs       = 8'($urandom_range(0, MAX_YEAR_OFS));
        r.month          = 8'($urandom_range(1, 12));
        dim              = month_days(BASE_YEAR + r.year_ofs, r.month);
        r.mday           = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(dim - 1, dim))
                                                       : 8'($urandom_range(1, dim));
        r.hour           = 8'($urandom_range(0, 23));
        r.minute         = 8'($urandom_range(0, 59));
        r.sec            = 8'($urandom_range(0, 59));
        pick = $urandom_range(0, 99);
        if (pick >= 72 && pick < 84) begin
            // framing error, date fields often garbage
            if ($urandom_range(0, 1)) begin
                r.write_offset   = 9'($urandom_range(1, 511));
                r.payload_length = 8'($urandom_range(0, 255));
            end else begin
                do r.payload_length = 8'($urandom_range(0, 255));
                while (r.payload_length == FRAME_LEN);
            end
            if ($urandom_range(0, 1)) begin
                r.year_ofs = 8'($urandom);
                r.month    = 8'($urandom);
                r.mday     = 8'($urandom);
                r.hour     = 8'($urandom);
                r.minute   = 8'($urandom);
                r.sec      = 8'($urandom);
            end
        end else if (pick >= 84) begin
            case ($urandom_range(0, 5))
                0: r.year_ofs = 8'($urandom_range(MAX_YEAR_OFS + 1, 255));
                1: r.month    = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(13, 255));
                2: r.mday     = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(dim + 1, 255));
                3: r.hour     = 8'($urandom_range(24, 255));
                4: r.minute   = 8'($urandom_range(60, 255));
                default: r.sec = 8'($urandom_range(60, 255));
            endcase
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        if (no_idle)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one beat and hold it until taken, then book its expectation
    task automatic send_beat(t_sync_rec r, bit typed, t_utc_result typed_res, bit last);
        int gap;
        start              <= 1'b1;
        i_write_offset     <= r.write_offset;
        i_payload_length   <= r.payload_length;
        i_year_since_2000  <= r.year_ofs;
        i_month_number     <= r.month;
        i_day_of_month     <= r.mday;
        i_hour_of_day      <= r.hour;
        i_minute_of_hour   <= r.minute;
        i_second_of_minute <= r.sec;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        utc_expect_q.push_back(typed ? typed_res : convert_record(r, zone_cfg));
        gap = last ? 0 : pick_gap();
        if (last || gap > 0)
            start <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic write_zone(logic signed [ZONE_W-1:0] value);
        while (utc_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        zone_cfg = value;
        zone_writes++;
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int beats);
        for (int i = 0; i < beats; i++) begin
            if (i % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_beat(rand_record(), 1'b0, '0, i == beats - 1);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_utc_result want;
        if (i_rst_n && o_valid) begin
            if (utc_expect_q.size() == 0) begin
                $error("unexpected beat: status %0d o_epoch_ms %0d", o_status, o_epoch_ms);
                err_cnt++;
            end else begin
                want = utc_expect_q.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    err_cnt++;
                end
                if (o_epoch_ms !== want.utc_ms) begin
                    $error("o_epoch_ms: expected %0d, actual %0d", want.utc_ms, o_epoch_ms);
                    err_cnt++;
                end
                case (want.status)
                    ST_OK:    n_converted++;
                    ST_FRAME: n_framing++;
                    default:  n_bad_date++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        logic signed [ZONE_W-1:0] zones [7];
        zones[0] = -ZONE_W'(50400);
        zones[1] = ZONE_W'(50400);
        zones[2] = '0;
        zones[3] = 17'sh10000;
        zones[4] = 17'sh0FFFF;
        zones[5] = ZONE_W'($urandom_range(0, 100800) - 50400);
        zones[6] = ZONE_W'($urandom_range(0, 100800) - 50400);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset zone offset, typed rows assume it
        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_tbl[i].rec, dir_tbl[i].typed, dir_tbl[i].res, i == DIR_ROWS - 1);

        foreach (zones[z]) begin
            write_zone(zones[z]);
            random_phase(PHASE_BEATS);
        end

        while (utc_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);

        $display("covered %0d conversions, %0d framing rejects, %0d date rejects",
                 n_converted, n_framing, n_bad_date);
        $display("across %0d zone offset writes plus the reset offset", zone_writes);
        if (err_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ldte_pkg.sv
src/ldte_check.sv
src/local_date_to_epoch_ms_top.sv
bench/testbench.sv
